// ----- rtl/core/slps_pkg.sv -----
// Shared types, mode codes, colors and scaling constants of the status LED sequencer.
// No dependencies; imported by every other file in rtl/core.
package slps_pkg;

	// widths of the transfer fields
	localparam int MODE_W    = 5;
	localparam int TIMEOUT_W = 24;
	localparam int BLINK_W   = 15;
	localparam int BEEP_W    = 2;
	localparam int LAMP_W    = 3;
	localparam int BTICK_W   = 8;
	localparam int ESTEP_W   = 5;

	// tick length and error cycle length
	localparam int TICK_MS     = 100;
	localparam int ERROR_STEPS = 20;

	// elapsed time is kept in ticks; one count above the limit stands for the saturated value
	localparam longint unsigned ELAPSED_MAX = (64'd1 << TIMEOUT_W) - 64'd1;
	localparam longint unsigned EL_LIMIT    = ELAPSED_MAX / TICK_MS;
	localparam longint unsigned EL_SAT      = EL_LIMIT + 64'd1;
	localparam int TICK_CNT_W = $clog2(EL_SAT + 64'd1);

	// exact divide by TICK_MS through a rounded-up reciprocal
	localparam int TICK_LOG = $clog2(TICK_MS);
	localparam int TMO_SHIFT = TIMEOUT_W + TICK_LOG;
	localparam int TMO_RECIP_W = TIMEOUT_W + 1;
	localparam longint unsigned TMO_RECIP = ((64'd1 << TMO_SHIFT) + TICK_MS - 1) / TICK_MS;
	localparam int BLK_SHIFT = BLINK_W + TICK_LOG;
	localparam int BLK_RECIP_W = BLINK_W + 1;
	localparam longint unsigned BLK_RECIP = ((64'd1 << BLK_SHIFT) + TICK_MS - 1) / TICK_MS;
	localparam int BLK_Q_W = BLINK_W + BLK_RECIP_W - BLK_SHIFT;

	// request codes
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_OFF         = 5'd0;
	localparam logic [MODE_W-1:0] MODE_GENERAL     = 5'd1;
	localparam logic [MODE_W-1:0] MODE_NORMAL      = 5'd2;
	localparam logic [MODE_W-1:0] MODE_DIAG_COMM   = 5'd3;
	localparam logic [MODE_W-1:0] MODE_REC_COMM    = 5'd4;
	localparam logic [MODE_W-1:0] MODE_NOTIFY      = 5'd5;
	localparam logic [MODE_W-1:0] MODE_RADIO_SCAN  = 5'd6;
	localparam logic [MODE_W-1:0] MODE_SEC_ERROR   = 5'd7;
	localparam logic [MODE_W-1:0] MODE_SRV_CONN    = 5'd8;
	localparam logic [MODE_W-1:0] MODE_SRV_SCAN    = 5'd9;
	localparam logic [MODE_W-1:0] MODE_SRV_TIMEOUT = 5'd10;
	localparam logic [MODE_W-1:0] MODE_NO_LINK     = 5'd11;
	localparam logic [MODE_W-1:0] MODE_NO_SERVER   = 5'd12;
	localparam logic [MODE_W-1:0] MODE_REPROG_ERR  = 5'd13;
	localparam logic [MODE_W-1:0] MODE_REPROG_DONE = 5'd14;
	localparam logic [MODE_W-1:0] MODE_REC_READY   = 5'd15;
	localparam logic [MODE_W-1:0] MODE_REC_TRIG    = 5'd16;
	localparam logic [MODE_W-1:0] MODE_REC_FAIL    = 5'd17;
	localparam logic [MODE_W-1:0] MODE_SIG_STRONG  = 5'd18;
	localparam logic [MODE_W-1:0] MODE_SIG_MEDIUM  = 5'd19;
	localparam logic [MODE_W-1:0] MODE_SIG_WEAK    = 5'd20;

	// lamp colors: bit0 red, bit1 green, bit2 blue
	localparam logic [LAMP_W-1:0] C_OFF    = 3'd0;
	localparam logic [LAMP_W-1:0] C_RED    = 3'd1;
	localparam logic [LAMP_W-1:0] C_GREEN  = 3'd2;
	localparam logic [LAMP_W-1:0] C_YELLOW = 3'd3;
	localparam logic [LAMP_W-1:0] C_BLUE   = 3'd4;
	localparam logic [LAMP_W-1:0] C_WHITE  = 3'd7;

	// beep requests
	localparam logic [BEEP_W-1:0] BEEP_NONE  = 2'd0;
	localparam logic [BEEP_W-1:0] BEEP_TWO   = 2'd2;
	localparam logic [BEEP_W-1:0] BEEP_THREE = 2'd3;

	// item after scaling, held in the input stage
	typedef struct packed {
		logic                  req_type;
		logic [MODE_W-1:0]     new_mode;
		logic [TICK_CNT_W-1:0] tmo_ticks;
		logic [BTICK_W-1:0]    blink_ticks;
		logic                  server_link;
		logic                  radio_link;
		logic                  inside_app;
	} item_t;

	// sequencer state
	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [TICK_CNT_W-1:0] tmo;
		logic [BTICK_W-1:0]    blink_ticks;
		logic [BTICK_W-1:0]    blink_cnt;
		logic [TICK_CNT_W-1:0] elapsed;
		logic [ESTEP_W-1:0]    err_step;
		logic                  scan_ph;
		logic                  srv_scan_ph;
		logic [LAMP_W-1:0]     lamp;
	} state_t;

	// one result
	typedef struct packed {
		logic [LAMP_W-1:0] lamp;
		logic [BEEP_W-1:0] beep;
		logic [MODE_W-1:0] mode;
	} result_t;

	// link fallback: lamp and mode
	typedef struct packed {
		logic [LAMP_W-1:0] lamp;
		logic [MODE_W-1:0] mode;
	} fallback_t;

	function automatic logic [LAMP_W-1:0] idle_color(input logic in_app);
		return in_app ? C_YELLOW : C_GREEN;
	endfunction

	function automatic fallback_t link_fallback(input logic server, input logic radio,
			input logic in_app);
		fallback_t fb;
		if (server) begin
			fb.lamp = C_BLUE;
			fb.mode = MODE_SRV_CONN;
		end else if (radio) begin
			fb.lamp = idle_color(in_app);
			fb.mode = MODE_NORMAL;
		end else begin
			fb.lamp = C_WHITE;
			fb.mode = MODE_GENERAL;
		end
		return fb;
	endfunction

endpackage

// ----- rtl/core/slps_ifs.sv -----
// Valid/ready channel interfaces of the status LED sequencer: command in, lamp state out.
// Depends on slps_pkg.
interface slps_cmd_if import slps_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [MODE_W-1:0]    new_mode;
	logic [TIMEOUT_W-1:0] timeout_ms;
	logic [BLINK_W-1:0]   blink_ms;
	logic                 server_link;
	logic                 radio_link;
	logic                 inside_app;

	modport source (output valid, req_type, new_mode, timeout_ms, blink_ms, server_link,
		radio_link, inside_app, input ready);
	modport sink (input valid, req_type, new_mode, timeout_ms, blink_ms, server_link,
		radio_link, inside_app, output ready);
endinterface

interface slps_led_if import slps_pkg::*;;
	logic              valid;
	logic              ready;
	logic              red_on;
	logic              green_on;
	logic              blue_on;
	logic [BEEP_W-1:0] beep_count;
	logic [MODE_W-1:0] mode_now;

	modport source (output valid, red_on, green_on, blue_on, beep_count, mode_now,
		input ready);
	modport sink (input valid, red_on, green_on, blue_on, beep_count, mode_now,
		output ready);
endinterface

// ----- rtl/core/slps_scale.sv -----
// Converts timeout and blink half period from milliseconds to ticks.
// Depends on slps_pkg; constant reciprocal multiply, no divider.
module slps_scale import slps_pkg::*; (
	input  logic [TIMEOUT_W-1:0]  timeout_ms,
	input  logic [BLINK_W-1:0]    blink_ms,
	output logic [TICK_CNT_W-1:0] tmo_ticks,
	output logic [BTICK_W-1:0]    blink_ticks
);

	localparam int TMO_PROD_W = TIMEOUT_W + TMO_RECIP_W;
	localparam int BLK_PROD_W = BLINK_W + BLK_RECIP_W;

	logic [TMO_PROD_W-1:0] tmo_prod;
	logic [BLK_PROD_W-1:0] blk_prod;
	logic [BLK_Q_W-1:0]    blk_q;

	// floor(x / TICK_MS) exactly for every input value
	assign tmo_prod = TMO_PROD_W'(timeout_ms) * TMO_PROD_W'(TMO_RECIP);
	assign blk_prod = BLK_PROD_W'(blink_ms) * BLK_PROD_W'(BLK_RECIP);

	assign tmo_ticks = tmo_prod[TMO_SHIFT +: TICK_CNT_W];
	assign blk_q     = blk_prod[BLK_SHIFT +: BLK_Q_W];

	// blink period saturates at 8 bits
	assign blink_ticks = (blk_q > BLK_Q_W'({BTICK_W{1'b1}})) ? {BTICK_W{1'b1}}
		: blk_q[BTICK_W-1:0];

endmodule

// ----- rtl/core/slps_rule.sv -----
// Next-state and result logic for one item: set-mode command or one tick of the mode rule.
// Depends on slps_pkg.
module slps_rule import slps_pkg::*; (
	input  state_t  st,
	input  item_t   item,
	output state_t  ns,
	output result_t res
);

	logic [BTICK_W-1:0]    cnt_inc;
	logic                  due;
	logic [BTICK_W-1:0]    cnt_blink;
	logic [TICK_CNT_W-1:0] el_next;
	logic                  tmo_hit;
	logic [ESTEP_W:0]      err_next;
	logic [LAMP_W-1:0]     err_lamp;
	logic [BEEP_W-1:0]     beep;
	fallback_t             fb;

	// blink counter advance
	assign cnt_inc   = st.blink_cnt + BTICK_W'(1);
	assign due       = (cnt_inc >= st.blink_ticks);
	assign cnt_blink = due ? '0 : cnt_inc;

	// elapsed ticks, saturating
	assign el_next = (st.elapsed >= TICK_CNT_W'(EL_LIMIT)) ? TICK_CNT_W'(EL_SAT)
		: st.elapsed + TICK_CNT_W'(1);
	assign tmo_hit = (el_next >= st.tmo);

	assign fb = link_fallback(item.server_link, item.radio_link, item.inside_app);

	// error cycle color
	assign err_next = {1'b0, st.err_step} + (ESTEP_W+1)'(1);
	always_comb begin
		case (err_next[1:0])
			2'd1:    err_lamp = C_RED;
			2'd2:    err_lamp = C_GREEN;
			2'd3:    err_lamp = C_BLUE;
			default: err_lamp = C_YELLOW;
		endcase
	end

	always_comb begin
		ns   = st;
		beep = BEEP_NONE;
		if (item.req_type == REQ_SET) begin
			ns.mode        = item.new_mode;
			ns.tmo         = item.tmo_ticks;
			ns.blink_ticks = item.blink_ticks;
			ns.elapsed     = '0;
		end else begin
			ns.elapsed = el_next;
			case (st.mode) inside
				MODE_OFF: begin
					ns.lamp      = C_OFF;
					ns.blink_cnt = '0;
				end
				MODE_GENERAL: begin
					ns.lamp      = st.lamp | C_WHITE;
					ns.blink_cnt = '0;
				end
				MODE_NORMAL: begin
					ns.lamp      = st.lamp | idle_color(item.inside_app);
					ns.blink_cnt = '0;
				end
				MODE_DIAG_COMM, MODE_REC_COMM, MODE_RADIO_SCAN, MODE_SRV_SCAN: begin
					ns.blink_cnt = cnt_blink;
					if (due) begin
						if (st.mode == MODE_DIAG_COMM) begin
							ns.lamp = st.lamp ^ (item.server_link ? C_BLUE : C_GREEN);
						end else if (st.mode == MODE_REC_COMM) begin
							ns.lamp = st.lamp ^ C_YELLOW;
						end else if (st.mode == MODE_RADIO_SCAN) begin
							if (!st.scan_ph) begin
								ns.lamp = (st.lamp | C_RED) & ~C_BLUE;
							end else begin
								ns.lamp = (st.lamp & ~C_RED) | C_BLUE;
							end
							ns.scan_ph = !st.scan_ph;
						end else begin
							ns.lamp        = st.srv_scan_ph ? C_YELLOW : C_BLUE;
							ns.srv_scan_ph = !st.srv_scan_ph;
						end
					end
					if (tmo_hit) begin
						ns.lamp      = fb.lamp;
						ns.mode      = fb.mode;
						ns.blink_cnt = '0;
					end
				end
				MODE_NOTIFY, MODE_SRV_TIMEOUT, MODE_NO_LINK, MODE_NO_SERVER: begin
					ns.blink_cnt = cnt_blink;
					if (due) begin
						ns.lamp = st.lamp ^ ((st.mode == MODE_NOTIFY || st.mode == MODE_NO_LINK)
							? C_RED : C_YELLOW);
					end
					if (tmo_hit) begin
						beep       = (st.mode == MODE_SRV_TIMEOUT) ? BEEP_TWO : BEEP_THREE;
						ns.elapsed = '0;
					end
				end
				MODE_SEC_ERROR: begin
					ns.blink_cnt = cnt_blink;
					if (due) begin
						ns.lamp = err_lamp;
						if (err_next > (ESTEP_W+1)'(ERROR_STEPS)) begin
							ns.err_step = '0;
							ns.lamp     = fb.lamp;
							ns.mode     = fb.mode;
						end else begin
							ns.err_step = err_next[ESTEP_W-1:0];
						end
					end
					if (tmo_hit) begin
						beep       = BEEP_THREE;
						ns.elapsed = '0;
					end
				end
				MODE_SRV_CONN: begin
					ns.lamp      = st.lamp | C_BLUE;
					ns.blink_cnt = '0;
				end
				MODE_REPROG_ERR: begin
					ns.lamp      = st.lamp | C_RED;
					ns.blink_cnt = '0;
				end
				MODE_REPROG_DONE: begin
					ns.lamp = st.lamp | (item.server_link ? C_BLUE
						: (item.radio_link ? C_GREEN : C_WHITE));
					ns.blink_cnt = '0;
				end
				MODE_REC_READY: begin
					ns.lamp      = st.lamp | C_YELLOW;
					ns.blink_cnt = '0;
				end
				MODE_REC_TRIG: begin
					ns.blink_cnt = cnt_blink;
					if (due) begin
						ns.lamp = st.lamp ^ C_YELLOW;
					end
					// a zero timeout never ends the trigger mode
					if (st.tmo != '0 && tmo_hit) begin
						ns.lamp      = C_YELLOW;
						ns.blink_cnt = '0;
						ns.mode      = MODE_REC_READY;
					end
				end
				MODE_REC_FAIL: begin
					ns.blink_cnt = cnt_blink;
					if (due) begin
						ns.lamp = st.lamp ^ C_RED;
					end
					if (tmo_hit) begin
						ns.lamp      = C_OFF;
						ns.blink_cnt = '0;
						ns.mode      = MODE_OFF;
					end
				end
				MODE_SIG_STRONG, MODE_SIG_MEDIUM, MODE_SIG_WEAK: begin
					ns.blink_cnt = cnt_blink;
					if (due) begin
						ns.lamp = st.lamp ^ ((st.mode == MODE_SIG_STRONG) ? C_BLUE
							: (st.mode == MODE_SIG_MEDIUM) ? C_YELLOW : C_WHITE);
					end
					if (tmo_hit) begin
						ns.lamp      = C_BLUE;
						ns.blink_cnt = '0;
						ns.mode      = MODE_SRV_CONN;
					end
				end
				default: begin
					// unnamed modes: link fallback on timeout
					if (tmo_hit) begin
						ns.lamp    = fb.lamp;
						ns.mode    = fb.mode;
						ns.elapsed = '0;
					end
				end
			endcase
		end
	end

	assign res.lamp = ns.lamp;
	assign res.beep = beep;
	assign res.mode = ns.mode;

endmodule

// ----- rtl/core/status_led_pattern_sequencer_top.sv -----
// Top level of the RGB status LED sequencer: input stage, mode rule, result stage.
// Depends on slps_pkg, slps_ifs (channel interfaces), slps_scale and slps_rule.
//
//  channel | dir | fields                                              | meaning
//  --------+-----+-----------------------------------------------------+---------------------
//  cmd     | in  | req_type new_mode timeout_ms blink_ms                | tick or set-mode,
//          |     | server_link radio_link inside_app                   | link flags
//  led     | out | red_on green_on blue_on beep_count mode_now          | lamp, beep, mode
//
// Flow: one transfer per clock sustained while led.ready stays high; a cmd transfer reaches
//   the led channel through stage 1 (scaled item registered) and then stage 2 (rule result
//   registered).
// The mode rule updates the sequencer state in the same cycle that the item leaves
//   stage 1, so back-to-back items see each other's state with no bubble.
// Stalls: led.ready low holds stage 2; cmd.ready drops only when both stages are full.
// Reset: arst_n clears the state (mode off, lamp dark) and both stage valids.
module status_led_pattern_sequencer_top import slps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	slps_cmd_if.sink  cmd,
	slps_led_if.source led
);

	// stage 1: scaled item
	logic   valid_s1;
	item_t  item_s1;
	// stage 2: result
	logic    valid_s2;
	result_t res_s2;
	// sequencer state
	state_t st_q;

	item_t   item_in;
	state_t  st_next;
	result_t res_next;
	logic    advance;

	// millisecond fields to ticks ahead of the input register
	slps_scale u_scale (
		.timeout_ms  (cmd.timeout_ms),
		.blink_ms    (cmd.blink_ms),
		.tmo_ticks   (item_in.tmo_ticks),
		.blink_ticks (item_in.blink_ticks)
	);

	assign item_in.req_type    = cmd.req_type;
	assign item_in.new_mode    = cmd.new_mode;
	assign item_in.server_link = cmd.server_link;
	assign item_in.radio_link  = cmd.radio_link;
	assign item_in.inside_app  = cmd.inside_app;

	slps_rule u_rule (
		.st   (st_q),
		.item (item_s1),
		.ns   (st_next),
		.res  (res_next)
	);

	// stage 2 moves when empty or being drained; stage 1 accepts when empty or when it can move on
	assign advance   = !valid_s2 || led.ready;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					st_q <= st_next;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= item_in;
		end
		if (advance && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign led.valid      = valid_s2;
	assign led.red_on     = res_s2.lamp[0];
	assign led.green_on   = res_s2.lamp[1];
	assign led.blue_on    = res_s2.lamp[2];
	assign led.beep_count = res_s2.beep;
	assign led.mode_now   = res_s2.mode;

endmodule

// ----- rtl/core/slps_checker.sv -----
// Port-level checks of the status LED sequencer, bound to the top level.
// Depends on slps_pkg and status_led_pattern_sequencer_top.
module slps_checker import slps_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              led_valid,
	input logic              led_ready,
	input logic [BEEP_W-1:0] beep_count,
	input logic [MODE_W-1:0] mode_now
);

	// items taken but not yet delivered
	logic [1:0] pend_q;
	logic       cmd_x;
	logic       led_x;

	assign cmd_x = cmd_valid && cmd_ready;
	assign led_x = led_valid && led_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(cmd_x) - 2'(led_x);
		end
	end

	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !led_ready |=> led_valid)
		else $error("led transfer withdrawn while stalled");

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items in flight");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid |-> pend_q != 2'd0)
		else $error("result with no pending item");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> led_valid && !led_ready)
		else $error("cmd stalled while output can drain");

	a_two_beeps: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && beep_count == BEEP_TWO |-> mode_now == MODE_SRV_TIMEOUT)
		else $error("two-beep request outside server timeout mode");

endmodule

bind status_led_pattern_sequencer_top slps_checker u_slps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.led_valid  (led.valid),
	.led_ready  (led.ready),
	.beep_count (led.beep_count),
	.mode_now   (led.mode_now)
);

// ----- sim/tb.sv -----
// Self-checking testbench for status_led_pattern_sequencer_top: drives ticks and set-mode
// commands over the cmd channel and checks every led transfer against a built-in predictor.
// Depends on rtl/core/slps_pkg.sv, rtl/core/slps_ifs.sv and the RTL of the sequencer.
`timescale 1ns / 100ps

module tb;
	import slps_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_ITEMS  = 1550;
	localparam int QUIET_LIMIT   = 500;   // idle cycles before the run is declared hung
	localparam int DRAIN_CYCLES  = 8;     // pipeline is two stages deep

	// one command as queued for the driver, with its idle draws
	typedef struct {
		logic                 req;
		logic [MODE_W-1:0]    mode;
		logic [TIMEOUT_W-1:0] tmo;
		logic [BLINK_W-1:0]   blk;
		logic                 server;
		logic                 radio;
		logic                 in_app;
		int                   gap;    // cycles the driver waits before presenting it
		int                   hold;   // cycles ready stays low after its result is taken
	} led_cmd_t;

	// lamp, beep and mode expected on the led channel
	typedef struct {
		logic [LAMP_W-1:0] lamp;
		logic [BEEP_W-1:0] beep;
		logic [MODE_W-1:0] mode;
		int                hold;
	} lamp_state_t;

	// predictor copy of the sequencer state
	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [TIMEOUT_W-1:0] limit;
		logic [BTICK_W-1:0]   bticks;
		logic [BTICK_W-1:0]   bcnt;
		logic [TIMEOUT_W-1:0] elapsed;
		logic [ESTEP_W-1:0]   estep;
		logic                 scan;
		logic                 sscan;
		logic [LAMP_W-1:0]    lamp;
	} seq_state_t;

	logic clk = 1'b0;
	logic arst_n;

	slps_cmd_if cmd_ch ();
	slps_led_if led_ch ();

	status_led_pattern_sequencer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.led    (led_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	led_cmd_t    cmd_backlog[$];     // commands not yet presented
	lamp_state_t lamp_expected[$];   // predicted results, oldest first
	seq_state_t  seq;
	led_cmd_t    cur_cmd;
	lamp_state_t predicted;
	lamp_state_t want;
	logic        holding;            // driver owns a command it has not yet transferred
	int          gap_left;
	int          stall_left;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          queued = 0;
	logic        steady = 1'b0;      // when set, queued commands carry no idle draws

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// blink counter advance; true when the half period is reached
	function automatic logic blink_step();
		seq.bcnt = seq.bcnt + 8'd1;
		if (seq.bcnt >= seq.bticks) begin
			seq.bcnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// idle colour and mode picked from the link flags
	function automatic void drop_to_link(input logic server, input logic radio,
			input logic in_app);
		if (server) begin
			seq.lamp = C_BLUE;
			seq.mode = MODE_SRV_CONN;
		end else if (radio) begin
			seq.lamp = in_app ? C_YELLOW : C_GREEN;
			seq.mode = MODE_NORMAL;
		end else begin
			seq.lamp = C_WHITE;
			seq.mode = MODE_GENERAL;
		end
	endfunction

	function automatic lamp_state_t advance_sequencer(input led_cmd_t c);
		lamp_state_t       r;
		logic [BEEP_W-1:0] beep;
		int unsigned       q;
		int unsigned       el;
		logic [5:0]        nstep;
		logic              late;
		beep = BEEP_NONE;
		if (c.req == REQ_SET) begin
			q = c.tmo;
			seq.mode    = c.mode;
			seq.limit   = 24'(q - q % TICK_MS);
			seq.elapsed = '0;
			q = c.blk / TICK_MS;
			seq.bticks  = (q > 255) ? 8'd255 : 8'(q);
		end else begin
			el = seq.elapsed + TICK_MS;
			seq.elapsed = (el > ELAPSED_MAX) ? 24'(ELAPSED_MAX) : 24'(el);
			late = seq.elapsed >= seq.limit;
			case (seq.mode)
				MODE_OFF: begin
					seq.lamp = C_OFF;
					seq.bcnt = '0;
				end
				MODE_GENERAL: begin
					seq.lamp |= C_WHITE;
					seq.bcnt = '0;
				end
				MODE_NORMAL: begin
					seq.lamp |= c.in_app ? C_YELLOW : C_GREEN;
					seq.bcnt = '0;
				end
				MODE_DIAG_COMM, MODE_REC_COMM, MODE_RADIO_SCAN, MODE_SRV_SCAN: begin
					if (blink_step()) begin
						case (seq.mode)
							MODE_DIAG_COMM: seq.lamp ^= c.server ? C_BLUE : C_GREEN;
							MODE_REC_COMM:  seq.lamp ^= C_YELLOW;
							MODE_RADIO_SCAN: begin
								if (!seq.scan) seq.lamp = (seq.lamp | C_RED) & ~C_BLUE;
								else seq.lamp = (seq.lamp & ~C_RED) | C_BLUE;
								seq.scan = ~seq.scan;
							end
							default: begin
								seq.lamp = seq.sscan ? C_YELLOW : C_BLUE;
								seq.sscan = ~seq.sscan;
							end
						endcase
					end
					if (late) begin
						drop_to_link(c.server, c.radio, c.in_app);
						seq.bcnt = '0;
					end
				end
				MODE_NOTIFY, MODE_SRV_TIMEOUT, MODE_NO_LINK, MODE_NO_SERVER: begin
					if (blink_step())
						seq.lamp ^= (seq.mode == MODE_NOTIFY || seq.mode == MODE_NO_LINK) ?
							C_RED : C_YELLOW;
					if (late) begin
						beep = (seq.mode == MODE_SRV_TIMEOUT) ? BEEP_TWO : BEEP_THREE;
						seq.elapsed = '0;
					end
				end
				MODE_SEC_ERROR: begin
					if (blink_step()) begin
						nstep = {1'b0, seq.estep} + 6'd1;
						case (nstep[1:0])
							2'd1:    seq.lamp = C_RED;
							2'd2:    seq.lamp = C_GREEN;
							2'd3:    seq.lamp = C_BLUE;
							default: seq.lamp = C_YELLOW;
						endcase
						if (nstep > ERROR_STEPS) begin
							seq.estep = '0;
							drop_to_link(c.server, c.radio, c.in_app);
						end else begin
							seq.estep = nstep[ESTEP_W-1:0];
						end
					end
					if (late) begin
						beep = BEEP_THREE;
						seq.elapsed = '0;
					end
				end
				MODE_SRV_CONN: begin
					seq.lamp |= C_BLUE;
					seq.bcnt = '0;
				end
				MODE_REPROG_ERR: begin
					seq.lamp |= C_RED;
					seq.bcnt = '0;
				end
				MODE_REPROG_DONE: begin
					seq.lamp |= c.server ? C_BLUE : (c.radio ? C_GREEN : C_WHITE);
					seq.bcnt = '0;
				end
				MODE_REC_READY: begin
					seq.lamp |= C_YELLOW;
					seq.bcnt = '0;
				end
				MODE_REC_TRIG: begin
					if (blink_step()) seq.lamp ^= C_YELLOW;
					// a zero limit means the trigger pattern runs forever
					if (seq.limit != '0 && late) begin
						seq.lamp = C_YELLOW;
						seq.bcnt = '0;
						seq.mode = MODE_REC_READY;
					end
				end
				MODE_REC_FAIL: begin
					if (blink_step()) seq.lamp ^= C_RED;
					if (late) begin
						seq.lamp = C_OFF;
						seq.bcnt = '0;
						seq.mode = MODE_OFF;
					end
				end
				MODE_SIG_STRONG, MODE_SIG_MEDIUM, MODE_SIG_WEAK: begin
					if (blink_step())
						seq.lamp ^= (seq.mode == MODE_SIG_STRONG) ? C_BLUE :
							(seq.mode == MODE_SIG_MEDIUM) ? C_YELLOW : C_WHITE;
					if (late) begin
						seq.lamp = C_BLUE;
						seq.bcnt = '0;
						seq.mode = MODE_SRV_CONN;
					end
				end
				default: begin
					// unnamed modes only fall back on timeout
					if (late) begin
						drop_to_link(c.server, c.radio, c.in_app);
						seq.elapsed = '0;
					end
				end
			endcase
		end
		r.lamp = seq.lamp;
		r.beep = beep;
		r.mode = seq.mode;
		r.hold = 0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus queueing
	// ------------------------------------------------------------------

	task automatic push_cmd(input logic req, input logic [MODE_W-1:0] mode,
			input logic [TIMEOUT_W-1:0] tmo, input logic [BLINK_W-1:0] blk,
			input logic server, input logic radio, input logic in_app);
		led_cmd_t c;
		c.req    = req;
		c.mode   = mode;
		c.tmo    = tmo;
		c.blk    = blk;
		c.server = server;
		c.radio  = radio;
		c.in_app = in_app;
		c.gap    = steady ? 0 : $urandom_range(0, 3);
		c.hold   = steady ? 0 : $urandom_range(0, 3);
		cmd_backlog.push_back(c);
		queued++;
	endtask

	// set-mode command; the link flags are don't-care and get random values
	task automatic push_set(input logic [MODE_W-1:0] mode, input logic [TIMEOUT_W-1:0] tmo,
			input logic [BLINK_W-1:0] blk);
		logic [2:0] flags;
		flags = 3'($urandom);
		push_cmd(REQ_SET, mode, tmo, blk, flags[0], flags[1], flags[2]);
	endtask

	// tick; mode, timeout and blink fields are don't-care and get random values
	task automatic push_tick(input logic server, input logic radio, input logic in_app);
		push_cmd(REQ_TICK, 5'($urandom), 24'($urandom), 15'($urandom), server, radio, in_app);
	endtask

	task automatic push_random_tick();
		logic [2:0] flags;
		flags = 3'($urandom);
		push_tick(flags[0], flags[1], flags[2]);
	endtask

	// ------------------------------------------------------------------
	// Driver: presents queued commands, predicts each one as it transfers
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			holding = 1'b0;
			gap_left = 0;
			seq = '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predicted = advance_sequencer(cur_cmd);
				predicted.hold = cur_cmd.hold;
				lamp_expected.push_back(predicted);
				holding = 1'b0;
			end
			if (!holding && cmd_backlog.size() != 0) begin
				cur_cmd = cmd_backlog.pop_front();
				holding = 1'b1;
				gap_left = cur_cmd.gap;
			end
			// valid gets exactly one assignment per edge so back-to-back
			// transfers keep it high without a glitch
			if (holding && gap_left == 0) begin
				cmd_ch.valid       <= 1'b1;
				cmd_ch.req_type    <= cur_cmd.req;
				cmd_ch.new_mode    <= cur_cmd.mode;
				cmd_ch.timeout_ms  <= cur_cmd.tmo;
				cmd_ch.blink_ms    <= cur_cmd.blk;
				cmd_ch.server_link <= cur_cmd.server;
				cmd_ch.radio_link  <= cur_cmd.radio;
				cmd_ch.inside_app  <= cur_cmd.in_app;
			end else begin
				cmd_ch.valid <= 1'b0;
				if (holding) gap_left--;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compares each led transfer with the oldest prediction
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (led_ch.valid && led_ch.ready) begin
				if (lamp_expected.size() == 0) begin
					$error("led transfer with no command outstanding");
					mismatches++;
				end else begin
					want = lamp_expected.pop_front();
					check_field("red_on", 8'(want.lamp[0]), 8'(led_ch.red_on));
					check_field("green_on", 8'(want.lamp[1]), 8'(led_ch.green_on));
					check_field("blue_on", 8'(want.lamp[2]), 8'(led_ch.blue_on));
					check_field("beep_count", 8'(want.beep), 8'(led_ch.beep_count));
					check_field("mode_now", 8'(want.mode), 8'(led_ch.mode_now));
					stall_left = want.hold;
				end
			end
			if (stall_left > 0) begin
				led_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				led_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any stretch without a transfer on either side is a hang
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (led_ch.valid && led_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int               start;
		int               n;
		logic [MODE_W-1:0] m;
		logic [TIMEOUT_W-1:0] tmo;
		logic [BLINK_W-1:0]   blk;

		// known values on every input from time zero
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.req_type     = REQ_TICK;
		cmd_ch.new_mode     = MODE_OFF;
		cmd_ch.timeout_ms   = '0;
		cmd_ch.blink_ms     = '0;
		cmd_ch.server_link  = 1'b0;
		cmd_ch.radio_link   = 1'b0;
		cmd_ch.inside_app   = 1'b0;
		led_ch.ready        = 1'b0;

		// directed: tick straight out of reset, then each special case
		push_tick(1'b1, 1'b1, 1'b1);
		push_set(MODE_GENERAL, '0, '0);
		push_tick(1'b0, 1'b0, 1'b0);
		push_set(MODE_NORMAL, '0, '0);
		push_tick(1'b0, 1'b1, 1'b1);                     // inside the app: yellow is ORed onto the lamp
		push_tick(1'b0, 1'b1, 1'b0);
		push_set(MODE_SEC_ERROR, '0, '0);                // zero timeout: beep every tick
		push_tick(1'b0, 1'b0, 1'b0);
		push_set(5'd31, 24'hFFFFFF, 15'h7FFF);           // blink period saturates at 255
		push_tick(1'b1, 1'b1, 1'b1);
		push_set(5'd21, '0, '0);                         // unnamed mode falls back to white
		push_tick(1'b0, 1'b0, 1'b0);
		push_set(MODE_REC_TRIG, 24'd99, '0);             // rounds to zero: never times out
		push_tick(1'b0, 1'b0, 1'b0);
		push_tick(1'b0, 1'b0, 1'b0);
		push_set(MODE_REC_FAIL, 24'd100, 15'd150);       // goes dark on timeout
		push_tick(1'b0, 1'b0, 1'b0);
		push_set(MODE_SRV_TIMEOUT, 24'd100, 15'd100);    // two-beep request
		push_tick(1'b0, 1'b0, 1'b0);
		push_set(MODE_SIG_WEAK, 24'd200, '0);            // ends in server connected
		push_tick(1'b0, 1'b0, 1'b0);
		push_tick(1'b0, 1'b0, 1'b0);
		push_set(MODE_DIAG_COMM, '0, 15'd25599);         // server link picks blue fallback
		push_tick(1'b1, 1'b0, 1'b0);

		// random part: mostly a set-mode followed by a run of ticks
		start = queued;
		while (queued - start < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 6) == 0) begin
				// noise: any field, either request type
				push_cmd(1'($urandom), 5'($urandom), 24'($urandom), 15'($urandom),
					1'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				m = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(21, 31))
					: 5'($urandom_range(0, 20));
				tmo = ($urandom_range(0, 7) == 0) ? 24'($urandom)
					: 24'($urandom_range(0, 20) * TICK_MS + $urandom_range(0, 99));
				blk = ($urandom_range(0, 7) == 0) ? 15'($urandom)
					: 15'($urandom_range(0, 4) * TICK_MS + $urandom_range(0, 99));
				push_set(m, tmo, blk);
				// long runs let the error cycle wrap and slow blinks complete
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
				repeat (n) push_random_tick();
			end
		end
		steady = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every command to transfer and every result to return
		@(negedge clk);
		while (cmd_backlog.size() != 0 || holding || lamp_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && lamp_expected.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/slps_pkg.sv
rtl/core/slps_ifs.sv
rtl/core/slps_scale.sv
rtl/core/slps_rule.sv
rtl/core/status_led_pattern_sequencer_top.sv
rtl/core/slps_checker.sv
sim/tb.sv
